/* sv/rational_fraction_adder_unit_macros.svh */
// assertion helpers for the fraction adder
`ifndef RATIONAL_FRACTION_ADDER_UNIT_MACROS_SVH
`define RATIONAL_FRACTION_ADDER_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define RFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/rfa_pkg.sv */
package rfa_pkg;

	typedef struct packed {
		logic signed [31:0] num_a;
		logic        [30:0] den_a;
		logic signed [31:0] num_b;
		logic        [30:0] den_b;
	} rfa_in_t;

	typedef struct packed {
		logic signed [63:0] sum_num;
		logic signed [63:0] sum_den;
		logic               div_error;
	} rfa_out_t;

	// request to the shared divider
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} rfa_div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic [63:0] rem;
	} rfa_div_rsp_t;

endpackage

/* sv/rfa_divider.sv */
// signed 64-bit truncated divider, one quotient bit per cycle
module rfa_divider import rfa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rfa_div_req_t req,
	output rfa_div_rsp_t rsp
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic        qneg_q;
	logic        rneg_q;
	logic        done_q;

	logic [63:0] a_mag;
	logic [63:0] b_mag;
	logic [64:0] trial;
	logic [63:0] shifted;

	assign a_mag = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
	assign b_mag = req.divisor[63] ? (~req.divisor + 64'd1) : req.divisor;
	assign shifted = {rem_q[62:0], quo_q[63]};
	assign trial = {1'b0, shifted} - {1'b0, dvs_q};

	// restoring shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				rem_q  <= '0;
				quo_q  <= a_mag;
				dvs_q  <= b_mag;
				qneg_q <= req.dividend[63] ^ req.divisor[63];
				rneg_q <= req.dividend[63];
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign fix on the result
	assign rsp.done = done_q;
	assign rsp.quot = qneg_q ? (~quo_q + 64'd1) : quo_q;
	assign rsp.rem  = rneg_q ? (~rem_q + 64'd1) : rem_q;

endmodule

/* sv/rational_fraction_adder_unit.sv */
// operation: two euclid loops of data-dependent length, each remainder step one division,
// plus five more divisions and a short multiply/add sequence; the time per item depends
// on the operands and is set by the shared bit-serial divider
// throughput: one item at a time, in_ready stays low until the result is taken
// reset: arst_n asynchronous active low returns the sequencer to idle, no result pending
`include "rational_fraction_adder_unit_macros.svh"
module rational_fraction_adder_unit import rfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rfa_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rfa_out_t out_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_G1    = 4'd1;
	localparam logic [3:0] ST_G1W   = 4'd2;
	localparam logic [3:0] ST_PROD  = 4'd3;
	localparam logic [3:0] ST_COMW  = 4'd4;
	localparam logic [3:0] ST_SAW   = 4'd5;
	localparam logic [3:0] ST_SBW   = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_G2    = 4'd8;
	localparam logic [3:0] ST_G2W   = 4'd9;
	localparam logic [3:0] ST_RNW   = 4'd10;
	localparam logic [3:0] ST_RDW   = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [3:0]         state_q;
	logic signed [31:0] na_q;
	logic signed [31:0] nb_q;
	logic [30:0]        da_q;
	logic [30:0]        db_q;
	logic signed [63:0] x_q;
	logic signed [63:0] y_q;
	logic signed [63:0] com_q;
	logic signed [63:0] sa_q;
	logic signed [63:0] sb_q;
	logic signed [63:0] tot_q;
	logic signed [63:0] h_q;
	logic               mphase_q;
	rfa_out_t           res_q;
	rfa_div_req_t       dreq;
	rfa_div_rsp_t       drsp;

	rfa_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// divider operand selection per state
	always_comb begin
		dreq = '0;
		case (state_q)
			ST_G1, ST_G2: begin
				dreq.start    = (y_q != 64'sd0);
				dreq.dividend = x_q;
				dreq.divisor  = y_q;
			end
			ST_PROD: begin
				dreq.start    = 1'b1;
				dreq.dividend = com_q;
				dreq.divisor  = x_q;
			end
			ST_COMW: begin
				dreq.start    = drsp.done;
				dreq.dividend = drsp.quot;
				dreq.divisor  = {33'd0, da_q};
			end
			ST_SAW: begin
				dreq.start    = drsp.done;
				dreq.dividend = com_q;
				dreq.divisor  = {33'd0, db_q};
			end
			ST_MUL: begin
				dreq.start    = 1'b0;
			end
			ST_RNW: begin
				dreq.start    = drsp.done;
				dreq.dividend = com_q;
				dreq.divisor  = h_q;
			end
			ST_G2W: begin
				dreq.start    = drsp.done && (drsp.rem == 64'd0);
				dreq.dividend = tot_q;
				dreq.divisor  = y_q;
			end
			default: dreq = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mphase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						na_q <= in_data.num_a;
						nb_q <= in_data.num_b;
						da_q <= in_data.den_a;
						db_q <= in_data.den_b;
						x_q  <= {33'd0, in_data.den_a};
						y_q  <= {33'd0, in_data.den_b};
						if (in_data.den_a == 31'd0 || in_data.den_b == 31'd0) begin
							res_q   <= '{sum_num: '0, sum_den: '0, div_error: 1'b1};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_G1;
						end
					end
				end
				ST_G1: begin
					if (y_q == 64'sd0) begin
						// x holds gcd; form da*db into com
						com_q   <= $signed({33'd0, da_q}) * $signed({33'd0, db_q});
						state_q <= ST_PROD;
					end else begin
						state_q <= ST_G1W;
					end
				end
				ST_G1W: begin
					if (drsp.done) begin
						x_q     <= y_q;
						y_q     <= drsp.rem;
						state_q <= ST_G1;
					end
				end
				ST_PROD: state_q <= ST_COMW;
				ST_COMW: begin
					if (drsp.done) begin
						com_q   <= drsp.quot;
						state_q <= ST_SAW;
					end
				end
				ST_SAW: begin
					if (drsp.done) begin
						sa_q    <= drsp.quot;
						state_q <= ST_SBW;
					end
				end
				ST_SBW: begin
					if (drsp.done) begin
						sb_q     <= drsp.quot;
						mphase_q <= 1'b0;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					// two 32x33 products, one per cycle, summed
					if (!mphase_q) begin
						tot_q    <= 64'(na_q * $signed(sa_q[32:0]));
						mphase_q <= 1'b1;
					end else begin
						tot_q   <= tot_q + 64'(nb_q * $signed(sb_q[32:0]));
						x_q     <= tot_q + 64'(nb_q * $signed(sb_q[32:0]));
						y_q     <= com_q;
						state_q <= ST_G2;
					end
				end
				ST_G2: begin
					if (y_q == 64'sd0) begin
						h_q     <= x_q;
						state_q <= ST_RNW;
					end else begin
						state_q <= ST_G2W;
					end
				end
				ST_G2W: begin
					if (drsp.done) begin
						x_q <= y_q;
						y_q <= drsp.rem;
						if (drsp.rem == 64'd0) begin
							h_q     <= y_q;
							state_q <= ST_RNW;
						end else begin
							state_q <= ST_G2;
						end
					end
				end
				ST_RNW: begin
					if (drsp.done) begin
						res_q.sum_num   <= drsp.quot;
						res_q.div_error <= 1'b0;
						state_q         <= ST_RDW;
					end
				end
				ST_RDW: begin
					if (drsp.done) begin
						res_q.sum_den <= drsp.quot;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	`RFA_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`RFA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`RFA_ASSERT_IMP(a_err0, clk, arst_n, out_valid && out_data.div_error,
		out_data.sum_num == 64'sd0 && out_data.sum_den == 64'sd0)
	`RFA_ASSERT_NXT(a_go, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

/* tb/sv/rfa_sum_checker.sv */
`timescale 1ns / 1ps
module rfa_sum_checker import rfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  rfa_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  rfa_out_t out_data,
	output int       fail_count,
	output int       pending
);

	rfa_out_t sums_due[$];

	// euclid with truncated remainder, sign follows the dividend
	function automatic logic signed [63:0] trunc_gcd(logic signed [63:0] x,
			logic signed [63:0] y);
		logic signed [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic rfa_out_t fraction_sum(rfa_in_t f);
		rfa_out_t s;
		logic signed [63:0] na, nb, da, db, g, lcm, total, h;
		na = 64'(f.num_a);
		nb = 64'(f.num_b);
		da = {33'd0, f.den_a};
		db = {33'd0, f.den_b};
		s = '0;
		if (da == 0 || db == 0) begin
			s.div_error = 1'b1;
			return s;
		end
		g = trunc_gcd(da, db);
		lcm = (da * db) / g;
		total = na * (lcm / da) + nb * (lcm / db);
		h = trunc_gcd(total, lcm);
		s.sum_num = total / h;
		s.sum_den = lcm / h;
		return s;
	endfunction

	assign pending = sums_due.size();

	// predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		rfa_out_t exp_sum;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				sums_due.push_back(fraction_sum(in_data));
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected transfer: %0d/%0d err %0b",
							out_data.sum_num, out_data.sum_den, out_data.div_error);
					fail_count <= fail_count + 1;
				end else begin
					exp_sum = sums_due.pop_front();
					if (exp_sum.sum_num !== out_data.sum_num
							|| exp_sum.sum_den !== out_data.sum_den
							|| exp_sum.div_error !== out_data.div_error) begin
						if (fail_count < 10)
							$display("mismatch: exp %0d/%0d err %0b, got %0d/%0d err %0b",
								exp_sum.sum_num, exp_sum.sum_den, exp_sum.div_error,
								out_data.sum_num, out_data.sum_den, out_data.div_error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/sv/tb_rational_fraction_adder_unit.sv */
`timescale 1ns / 1ps
module tb_rational_fraction_adder_unit;
	import rfa_pkg::*;

	localparam int N_RANDOM = 100;
	localparam longint CYCLE_LIMIT = 64'd8000000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	rfa_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	rfa_out_t out_data;
	int       fail_count;
	int       pending;
	longint   cycles = 0;
	bit       calm = 1'b0;

	rational_fraction_adder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	rfa_sum_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 16);
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one input transfer, with optional idle burst first; valid is dropped only for idling
	task automatic send_fraction(rfa_in_t f);
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [30:0] rand_den();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(1, 12));
			1: return 31'($urandom_range(1, 1000));
			2: return 31'($urandom) | 31'd1;
			default: return 31'($urandom_range(1, 65535)) * 31'd6;
		endcase
	endfunction

	function automatic logic [31:0] rand_num();
		case ($urandom_range(0, 2))
			0: return 32'(int'($urandom_range(0, 40)) - 20);
			default: return 32'($urandom);
		endcase
	endfunction

	initial begin
		rfa_in_t f;
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero denominators, zero and negative sums
		send_fraction('{32'sd1, 31'd2, 32'sd1, 31'd3});
		send_fraction('{32'sd1, 31'd0, 32'sd1, 31'd3});
		send_fraction('{32'sd1, 31'd5, 32'sd1, 31'd0});
		send_fraction('{32'sd0, 31'd0, 32'sd0, 31'd0});
		send_fraction('{32'sd3, 31'd4, -32'sd3, 31'd4});
		send_fraction('{-32'sd1, 31'd2, -32'sd1, 31'd3});
		send_fraction('{-32'sd5, 31'd6, 32'sd1, 31'd4});
		send_fraction('{32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE});
		send_fraction('{32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
		send_fraction('{32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1});
		send_fraction('{32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1});
		send_fraction('{32'hFFFF_FFFF, 31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA});
		send_fraction('{32'sd0, 31'd7, 32'sd0, 31'd9});
		send_fraction('{32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
		send_fraction('{-32'sd7, 31'd1, 32'sd3, 31'h4000_0000});
		in_valid <= 1'b0;
		@(posedge clk);

		// pause until all results are back
		while (pending != 0) @(posedge clk);

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 15) calm = 1'b1;
			f.num_a = rand_num();
			f.num_b = rand_num();
			f.den_a = rand_den();
			f.den_b = ($urandom_range(0, 3) == 0) ? f.den_a : rand_den();
			if ($urandom_range(0, 29) == 0) f.den_a = '0;
			if ($urandom_range(0, 29) == 0) f.den_b = '0;
			send_fraction(f);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
